// ----- sv/bdgf_pkg.sv -----
// ----------------------------------------------------------------------------
// bdgf_pkg
// shared types and constants for the button debounce and ghost filter
// ----------------------------------------------------------------------------
package bdgf_pkg;

  // buttons that appear in the result word
  localparam int unsigned NUM_VISIBLE = 4;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned COUNT_W = 4;
  localparam int unsigned GHOST_W = 16;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 32;

  // register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_CONSISTENT = 2'd0,
    REG_GHOST_STD  = 2'd1,
    REG_GHOST_FAST = 2'd2,
    REG_FAST_MODE  = 2'd3
  } reg_idx_t;

  localparam logic [COUNT_W-1:0] RST_CONSISTENT = 4'd3;
  localparam logic [GHOST_W-1:0] RST_GHOST_STD  = 16'd50;
  localparam logic [GHOST_W-1:0] RST_GHOST_FAST = 16'd20;

  typedef struct packed {
    logic [COUNT_W-1:0] consistent_samples;
    logic [GHOST_W-1:0] ghost_ms_standard;
    logic [GHOST_W-1:0] ghost_ms_fast;
    logic               fast_mode;
  } cfg_t;

  // what one button lane needs from the config block
  typedef struct packed {
    logic [COUNT_W-1:0] need;
    logic [GHOST_W-1:0] ghost;
  } lane_cfg_t;

  // per-lane status toward the result register
  typedef struct packed {
    logic              pressed;
    logic              press_edge;
    logic [TIME_W-1:0] held;
  } lane_stat_t;

endpackage

// ----- sv/bdgf_regs.sv -----
// ----------------------------------------------------------------------------
// bdgf_regs
// apb config registers: sample count, ghost times, fast mode select
// ----------------------------------------------------------------------------
module bdgf_regs
  import bdgf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx        = reg_idx_t'(cfg_paddr[3:2]);
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_CONSISTENT: cfg_nxt.consistent_samples = cfg_pwdata[COUNT_W-1:0];
        REG_GHOST_STD:  cfg_nxt.ghost_ms_standard  = cfg_pwdata[GHOST_W-1:0];
        REG_GHOST_FAST: cfg_nxt.ghost_ms_fast      = cfg_pwdata[GHOST_W-1:0];
        REG_FAST_MODE:  cfg_nxt.fast_mode          = cfg_pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CONSISTENT: cfg_prdata = {{(DATA_W-COUNT_W){1'b0}}, cfg_r.consistent_samples};
      REG_GHOST_STD:  cfg_prdata = {{(DATA_W-GHOST_W){1'b0}}, cfg_r.ghost_ms_standard};
      REG_GHOST_FAST: cfg_prdata = {{(DATA_W-GHOST_W){1'b0}}, cfg_r.ghost_ms_fast};
      REG_FAST_MODE:  cfg_prdata = {{(DATA_W-1){1'b0}}, cfg_r.fast_mode};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.consistent_samples <= RST_CONSISTENT;
      cfg_r.ghost_ms_standard  <= RST_GHOST_STD;
      cfg_r.ghost_ms_fast      <= RST_GHOST_FAST;
      cfg_r.fast_mode          <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- sv/bdgf_lane.sv -----
// ----------------------------------------------------------------------------
// bdgf_lane
// one button: candidate level, match counter, candidate and press timestamps
// ----------------------------------------------------------------------------
module bdgf_lane
  import bdgf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  logic [TIME_W-1:0] now_ms,
  input  logic              raw,
  input  lane_cfg_t         lcfg,
  output lane_stat_t        stat
);

  logic               cand_r,  cand_nxt;
  logic [COUNT_W-1:0] cnt_r,   cnt_nxt;
  logic [TIME_W-1:0]  ctime_r, ctime_nxt;
  logic               conf_r,  conf_nxt;
  logic [TIME_W-1:0]  ptime_r, ptime_nxt;
  logic               count_met;
  logic [TIME_W-1:0]  age;
  logic               press_edge;

  always_comb begin
    cand_nxt   = raw;
    conf_nxt   = conf_r;
    ptime_nxt  = ptime_r;
    press_edge = 1'b0;

    if (raw == cand_r) begin
      cnt_nxt   = (cnt_r < lcfg.need) ? COUNT_W'(cnt_r + 1'b1) : cnt_r;
      ctime_nxt = ctime_r;
    end else begin
      cnt_nxt   = COUNT_W'(1);
      ctime_nxt = now_ms;
    end

    count_met = (cnt_nxt >= lcfg.need);
    age       = now_ms - ctime_nxt;

    if (count_met) begin
      if (cand_nxt) begin
        // press needs the candidate to be at least the ghost time old
        if (!conf_r && (age >= {{(TIME_W-GHOST_W){1'b0}}, lcfg.ghost})) begin
          conf_nxt   = 1'b1;
          ptime_nxt  = now_ms;
          press_edge = 1'b1;
        end
      end else begin
        conf_nxt  = 1'b0;
        ptime_nxt = '0;
      end
    end

    stat.pressed    = conf_nxt;
    stat.press_edge = press_edge;
    stat.held       = conf_nxt ? (now_ms - ptime_nxt) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r  <= 1'b0;
      cnt_r   <= '0;
      ctime_r <= '0;
      conf_r  <= 1'b0;
      ptime_r <= '0;
    end else if (advance) begin
      cand_r  <= cand_nxt;
      cnt_r   <= cnt_nxt;
      ctime_r <= ctime_nxt;
      conf_r  <= conf_nxt;
      ptime_r <= ptime_nxt;
    end
  end

endmodule

// ----- sv/button_debounce_ghost_filter.sv -----
// ----------------------------------------------------------------------------
// button_debounce_ghost_filter
// integrating-counter debounce with a minimum press age (ghost filter)
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+-----------------------------
//   in      | input     | in_valid / in_ready        | in_now_ms, in_raw_levels
//   out     | output    | out_valid / out_ready      | masks, first edge, held_ms_*
//   cfg     | input     | apb psel/penable, pready=1 | 4 registers at 4*i
//
// one word in, one word out; an accepted word passes through the input
// register, then the lane update into the result register
// one word per cycle sustained while the receiver takes the results, set by
// the per-button lane update which reads and writes the button state
// reset is synchronous, active low; all button state clears to released
// a full result register that is not taken holds the input register, and
// in_ready drops only when both stages are occupied
// ----------------------------------------------------------------------------
module button_debounce_ghost_filter
  import bdgf_pkg::*;
#(
  parameter int unsigned NUM_BUTTONS = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,

  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [TIME_W-1:0]           in_now_ms,
  input  logic [NUM_VISIBLE-1:0]      in_raw_levels,

  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [NUM_VISIBLE-1:0]      out_pressed_mask,
  output logic [NUM_VISIBLE-1:0]      out_edge_mask,
  output logic                        out_any_edge,
  output logic [1:0]                  out_first_edge_button,
  output logic [TIME_W-1:0]           out_held_ms_0,
  output logic [TIME_W-1:0]           out_held_ms_1,
  output logic [TIME_W-1:0]           out_held_ms_2,
  output logic [TIME_W-1:0]           out_held_ms_3,

  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [ADDR_W-1:0]           cfg_paddr,
  input  logic [DATA_W-1:0]           cfg_pwdata,
  output logic [DATA_W-1:0]           cfg_prdata,
  output logic                        cfg_pready
);

  // ---- config registers ----
  cfg_t      cfg;
  lane_cfg_t lcfg;

  bdgf_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // ghost time picked once for all lanes
  assign lcfg.need  = cfg.consistent_samples;
  assign lcfg.ghost = cfg.fast_mode ? cfg.ghost_ms_fast : cfg.ghost_ms_standard;

  // ---- input register ----
  logic                   s1_valid_r;
  logic [TIME_W-1:0]      s1_now_r;
  logic [NUM_VISIBLE-1:0] s1_raw_r;
  logic                   out_valid_r;
  logic                   advance;
  logic                   in_fire;

  // stage 1 moves into the result register when that slot is free or draining
  assign advance  = s1_valid_r & (~out_valid_r | out_ready);
  assign in_ready = ~s1_valid_r | advance;
  assign in_fire  = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_now_r <= in_now_ms;
      s1_raw_r <= in_raw_levels;
    end
  end

  // ---- button lanes ----
  // buttons past the visible four only ever see a released level and show up
  // in no output, so they are not built; lanes not present read as released
  lane_stat_t stat [NUM_VISIBLE];

  for (genvar g = 0; g < NUM_VISIBLE; g++) begin : g_lane
    if (g < NUM_BUTTONS) begin : g_on
      bdgf_lane u_lane (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .now_ms  (s1_now_r),
        .raw     (s1_raw_r[g]),
        .lcfg    (lcfg),
        .stat    (stat[g])
      );
    end else begin : g_off
      assign stat[g] = '0;
    end
  end

  // ---- result assembly ----
  logic [NUM_VISIBLE-1:0] pressed_nxt;
  logic [NUM_VISIBLE-1:0] edge_nxt;
  logic [1:0]             first_nxt;

  always_comb begin
    for (int i = 0; i < NUM_VISIBLE; i++) begin
      pressed_nxt[i] = stat[i].pressed;
      edge_nxt[i]    = stat[i].press_edge;
    end
  end

  // lowest numbered edge wins, zero when there is none
  always_comb begin
    priority if (edge_nxt[0]) first_nxt = 2'd0;
    else if (edge_nxt[1])     first_nxt = 2'd1;
    else if (edge_nxt[2])     first_nxt = 2'd2;
    else if (edge_nxt[3])     first_nxt = 2'd3;
    else                      first_nxt = 2'd0;
  end

  // ---- result register ----
  logic [NUM_VISIBLE-1:0] pressed_r;
  logic [NUM_VISIBLE-1:0] edge_r;
  logic                   any_edge_r;
  logic [1:0]             first_r;
  logic [TIME_W-1:0]      held0_r, held1_r, held2_r, held3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pressed_r  <= pressed_nxt;
      edge_r     <= edge_nxt;
      any_edge_r <= |edge_nxt;
      first_r    <= first_nxt;
      held0_r    <= stat[0].held;
      held1_r    <= stat[1].held;
      held2_r    <= stat[2].held;
      held3_r    <= stat[3].held;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_pressed_mask      = pressed_r;
  assign out_edge_mask         = edge_r;
  assign out_any_edge          = any_edge_r;
  assign out_first_edge_button = first_r;
  assign out_held_ms_0         = held0_r;
  assign out_held_ms_1         = held1_r;
  assign out_held_ms_2         = held2_r;
  assign out_held_ms_3         = held3_r;

endmodule

// ----- verif/tb_button_debounce_ghost_filter.sv -----
// ----------------------------------------------------------------------------
// tb_button_debounce_ghost_filter
// self-checking bench for the button debounce and ghost filter
//
// a queue of sampling ticks feeds a valid/ready driver and a monitor checks
// every result word against an in-bench debounce model. a short directed run
// at reset settings is followed by random phases, each under its own
// register setting and its own mix of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module tb_button_debounce_ghost_filter
  import bdgf_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // one sampling tick as it goes into the block
  typedef struct packed {
    logic [TIME_W-1:0]      now;
    logic [NUM_VISIBLE-1:0] lv;
  } tick_t;

  // one result word as it should come out
  typedef struct packed {
    logic [NUM_VISIBLE-1:0]             pressed;
    logic [NUM_VISIBLE-1:0]             edges;
    logic                               any;
    logic [1:0]                         first;
    logic [NUM_VISIBLE-1:0][TIME_W-1:0] held;
  } report_t;

  localparam int NUM_PHASES      = 8;
  localparam int WORDS_PER_PHASE = 230;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_valid      = 1'b0;
  logic                   in_ready;
  logic [TIME_W-1:0]      in_now_ms     = '0;
  logic [NUM_VISIBLE-1:0] in_raw_levels = '0;

  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [NUM_VISIBLE-1:0] out_pressed_mask;
  logic [NUM_VISIBLE-1:0] out_edge_mask;
  logic                   out_any_edge;
  logic [1:0]             out_first_edge_button;
  logic [TIME_W-1:0]      out_held_ms_0;
  logic [TIME_W-1:0]      out_held_ms_1;
  logic [TIME_W-1:0]      out_held_ms_2;
  logic [TIME_W-1:0]      out_held_ms_3;

  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr   = '0;
  logic [DATA_W-1:0] cfg_pwdata  = '0;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  // ticks waiting for the driver, and result words waiting for the block
  tick_t   tick_q[$];
  report_t expected_reports[$];

  // idle and stall odds in percent, set per phase
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  int errors       = 0;
  int words_queued = 0;
  int words_in     = 0;
  int words_out    = 0;
  int press_edges  = 0;
  int settings     = 0;

  // register shadow, starts at the reset values of the block
  logic [COUNT_W-1:0] need_cnt   = RST_CONSISTENT;
  logic [GHOST_W-1:0] ghost_std  = RST_GHOST_STD;
  logic [GHOST_W-1:0] ghost_fast = RST_GHOST_FAST;
  logic               fast_sel   = 1'b0;

  // per-button debounce state of the model, all released after reset
  logic                 cand_lvl  [NUM_VISIBLE] = '{default: 1'b0};
  logic [COUNT_W-1:0]   agree_cnt [NUM_VISIBLE] = '{default: '0};
  logic [TIME_W-1:0]    cand_ms   [NUM_VISIBLE] = '{default: '0};
  logic                 btn_down  [NUM_VISIBLE] = '{default: 1'b0};
  logic [TIME_W-1:0]    down_ms   [NUM_VISIBLE] = '{default: '0};

  button_debounce_ghost_filter dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_now_ms             (in_now_ms),
    .in_raw_levels         (in_raw_levels),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_pressed_mask      (out_pressed_mask),
    .out_edge_mask         (out_edge_mask),
    .out_any_edge          (out_any_edge),
    .out_first_edge_button (out_first_edge_button),
    .out_held_ms_0         (out_held_ms_0),
    .out_held_ms_1         (out_held_ms_1),
    .out_held_ms_2         (out_held_ms_2),
    .out_held_ms_3         (out_held_ms_3),
    .cfg_psel              (cfg_psel),
    .cfg_penable           (cfg_penable),
    .cfg_pwrite            (cfg_pwrite),
    .cfg_paddr             (cfg_paddr),
    .cfg_pwdata            (cfg_pwdata),
    .cfg_prdata            (cfg_prdata),
    .cfg_pready            (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // debounce model: advances the button state by one tick and returns the
  // result word that tick must produce
  function automatic report_t debounce_tick(tick_t t);
    report_t           r;
    logic [TIME_W-1:0] ghost;
    logic              hit;
    r = '0;
    ghost = fast_sel ? TIME_W'(ghost_fast) : TIME_W'(ghost_std);
    for (int i = 0; i < NUM_VISIBLE; i++) begin
      hit = 1'b0;
      // same level keeps counting up to the threshold, a new level restarts
      if (t.lv[i] == cand_lvl[i]) begin
        if (agree_cnt[i] < need_cnt) agree_cnt[i] = COUNT_W'(agree_cnt[i] + 1'b1);
      end else begin
        cand_lvl[i]  = t.lv[i];
        agree_cnt[i] = COUNT_W'(1);
        cand_ms[i]   = t.now;
      end
      // with a zero threshold this passes from the first sample
      if (agree_cnt[i] >= need_cnt) begin
        if (cand_lvl[i]) begin
          // press needs the candidate to be at least the ghost time old
          if (!btn_down[i] && (t.now - cand_ms[i]) >= ghost) begin
            btn_down[i] = 1'b1;
            down_ms[i]  = t.now;
            hit         = 1'b1;
          end
        end else begin
          // release is taken at once and forgets the press time
          btn_down[i] = 1'b0;
          down_ms[i]  = '0;
        end
      end
      if (btn_down[i]) begin
        r.pressed[i] = 1'b1;
        r.held[i]    = t.now - down_ms[i];
      end
      if (hit) begin
        if (r.edges == '0) r.first = 2'(i);
        r.edges[i] = 1'b1;
      end
    end
    r.any = |r.edges;
    return r;
  endfunction

  task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, want, got);
    end
  endtask

  // driver: offers the next tick once the previous one is taken, or holds
  // valid low on an idle draw; a held word never changes
  always @(posedge clk) begin
    tick_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = tick_q.pop_front();
        in_valid      <= 1'b1;
        in_now_ms     <= nxt.now;
        in_raw_levels <= nxt.lv;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: predicts on every accepted tick, checks every taken result,
  // and draws the receiver stalls
  always @(posedge clk) begin
    report_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (in_valid && in_ready) begin
        expected_reports.push_back(debounce_tick({in_now_ms, in_raw_levels}));
        words_in++;
      end
      if (out_valid && out_ready) begin
        words_out++;
        if (expected_reports.size() == 0) begin
          errors++;
          $display("%0t: result word with nothing expected, pressed %0h edges %0h",
                   $time, out_pressed_mask, out_edge_mask);
        end else begin
          want = expected_reports.pop_front();
          if (want.any) press_edges++;
          check_field("pressed_mask", 32'(want.pressed), 32'(out_pressed_mask));
          check_field("edge_mask", 32'(want.edges), 32'(out_edge_mask));
          check_field("any_edge", 32'(want.any), 32'(out_any_edge));
          check_field("first_edge_button", 32'(want.first), 32'(out_first_edge_button));
          check_field("held_ms_0", want.held[0], out_held_ms_0);
          check_field("held_ms_1", want.held[1], out_held_ms_1);
          check_field("held_ms_2", want.held[2], out_held_ms_2);
          check_field("held_ms_3", want.held[3], out_held_ms_3);
        end
      end
    end
  end

  // apb write, then a read back of the same register
  task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] val);
    logic [DATA_W-1:0] rb;
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    // register is written at this edge, go straight into the read setup
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_CONSISTENT: need_cnt   = val[COUNT_W-1:0];
      REG_GHOST_STD:  ghost_std  = val[GHOST_W-1:0];
      REG_GHOST_FAST: ghost_fast = val[GHOST_W-1:0];
      REG_FAST_MODE:  fast_sel   = val[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rb = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (rb !== val) begin
      errors++;
      $display("%0t: read back of register %s, expected %0h, got %0h",
               $time, idx.name(), val, rb);
    end
  endtask

  task automatic set_regs(logic [COUNT_W-1:0] need, logic [GHOST_W-1:0] gs,
                          logic [GHOST_W-1:0] gf, logic fm);
    write_reg(REG_CONSISTENT, DATA_W'(need));
    write_reg(REG_GHOST_STD, DATA_W'(gs));
    write_reg(REG_GHOST_FAST, DATA_W'(gf));
    write_reg(REG_FAST_MODE, DATA_W'(fm));
    settings++;
  endtask

  // block is idle once every queued tick has come back as a checked word;
  // an extra wait then lets the handshakes settle
  task automatic wait_drained();
    do @(posedge clk);
    while (words_out != words_queued);
    repeat (4) @(posedge clk);
  endtask

  task automatic push_tick(logic [TIME_W-1:0] now, logic [NUM_VISIBLE-1:0] lv);
    tick_q.push_back('{now: now, lv: lv});
    words_queued++;
  endtask

  // random phase: mostly steady holds that run past the threshold, with
  // the odd bounce, mixed with bursts of pure noise; time mostly creeps
  // forward but sometimes leaps far enough to pass the largest ghost time
  // or jumps anywhere, so wrap and backward time show up too
  task automatic gen_phase(int n);
    logic [TIME_W-1:0]      tnow;
    logic [NUM_VISIBLE-1:0] lv;
    int                     made;
    int                     len;
    int                     r;
    made = 0;
    tnow = ($urandom_range(3) == 0) ? 32'hFFFF_FF00 : $urandom;
    while (made < n) begin
      if ($urandom_range(99) < 80) begin
        lv  = NUM_VISIBLE'($urandom);
        len = need_cnt + $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
          r = $urandom_range(99);
          if (r < 70) tnow += $urandom_range(0, 40);
          else if (r < 95) tnow += $urandom_range(0, 70000);
          else tnow = $urandom;
          // single-bit bounce on one tick
          if ($urandom_range(99) < 15) push_tick(tnow, lv ^ (4'b1 << $urandom_range(0, 3)));
          else push_tick(tnow, lv);
          made++;
        end
      end else begin
        len = $urandom_range(1, 4);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(1) == 0) tnow = $urandom;
          else tnow += $urandom_range(0, 20);
          push_tick(tnow, NUM_VISIBLE'($urandom));
          made++;
        end
      end
    end
  endtask

  // generous cap on the whole run
  initial begin
    #5_000_000;
    $display("button_debounce_ghost_filter regression: fail");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at reset settings (threshold 3, standard ghost 50)
    // all four pressed while time wraps through zero; press lands at 18
    for (int k = 0; k < 7; k++) push_tick(32'hFFFF_FFE0 + 10 * k, 4'hF);
    // button 0 lets go, released on the third sample
    push_tick(32'h26, 4'hE);
    push_tick(32'h30, 4'hE);
    push_tick(32'h3A, 4'hE);
    // everything released
    push_tick(32'h44, 4'h0);
    push_tick(32'h4E, 4'h0);
    push_tick(32'h58, 4'h0);
    // time steps back to zero
    push_tick(32'h0, 4'h0);
    // buttons 2 and 3 with a bounce on 3, count met while still too young
    push_tick(32'd100, 4'hC);
    push_tick(32'd101, 4'h4);
    push_tick(32'd102, 4'hC);
    push_tick(32'd103, 4'hC);
    push_tick(32'd104, 4'hC);
    // old enough now: both edge on one tick, lowest edge button is 2
    push_tick(32'd250, 4'hC);
    // all-ones time, held time goes huge
    push_tick(32'hFFFF_FFFF, 4'hC);
    // 2 and 3 released, 0 and 1 start a new candidate
    push_tick(32'd300, 4'h3);
    push_tick(32'd310, 4'h3);
    push_tick(32'd320, 4'h3);
    push_tick(32'd400, 4'h3);
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        // immediate action with zero ghost, then the largest threshold with a zero fast ghost
        0: set_regs(4'd1, 16'd0, 16'hFFFF, 1'b0);
        1: set_regs(4'd15, 16'hFFFF, 16'd0, 1'b1);
        // zero threshold acts on the first sample
        2: set_regs(4'd0, 16'd100, 16'd5, 1'b0);
        3: set_regs(4'd2, 16'hFFFF, 16'd30, 1'b0);
        default: set_regs(COUNT_W'($urandom_range(0, 15)),
                          ($urandom_range(3) == 0) ? GHOST_W'($urandom_range(0, 65535))
                                                   : GHOST_W'($urandom_range(0, 200)),
                          ($urandom_range(3) == 0) ? GHOST_W'($urandom_range(0, 65535))
                                                   : GHOST_W'($urandom_range(0, 60)),
                          1'($urandom_range(1)));
      endcase
      // idle mix rotates: none, sender idle, receiver stall, both light
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      gen_phase(WORDS_PER_PHASE);
      wait_drained();
    end

    repeat (10) @(posedge clk);
    $display("run covered %0d ticks in, %0d result words checked, %0d with a press edge",
             words_in, words_out, press_edges);
    $display("register settings applied: %0d, mismatches: %0d", settings, errors);
    if (errors == 0) begin
      $display("button_debounce_ghost_filter regression: pass");
    end else begin
      $display("button_debounce_ghost_filter regression: fail");
    end
    $finish;
  end

endmodule
